// ----- hw/rtl/frp_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Types, codes and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package frp_pkg;

  typedef enum logic [2:0] {
    FRP_PROGRESS = 3'd0,
    FRP_GOOD     = 3'd1,
    FRP_HDR_BAD  = 3'd2,
    FRP_LEN_BAD  = 3'd3,
    FRP_TAIL_BAD = 3'd4
  } frp_status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic        in_frame;
    frp_status_e status;
    logic [15:0] frame_length;
  } frp_result_t;

  localparam logic [31:0] HDR_WORD     = 32'h5B44_4D2D;
  localparam logic [31:0] TAIL_WORD    = 32'h2D4E_525D;
  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_LEN      = 32'd16;
  localparam logic [16:0] HDR_LEN      = 17'd4;
  localparam logic [16:0] PREFIX_LEN   = 17'd8;
  localparam logic [16:0] LIMIT_CAP    = 17'h1_0000;
  localparam logic [16:0] LIMIT_RESET  = 17'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_LENGTH_LIMIT = 1'b0;

  typedef logic [31:0][31:0] crc_cols_t;

  // CRC of a single set bit pushed through 32 shifts, one column per bit
  function automatic crc_cols_t crc_cols_f();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int j = 0; j < 32; j++) begin
        if (c[31]) begin
          c = (c << 1) ^ CRC_POLY;
        end else begin
          c = c << 1;
        end
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols_f();

endpackage

// ----- hw/rtl/frp_crc32_word.sv -----
// ----------------------------------------------------------------------------
// CRC-32 word update
// Folds one 32-bit word into the running CRC, MSB first, as an XOR matrix.
// ----------------------------------------------------------------------------
module frp_crc32_word (
  input  logic [31:0] crc_i,
  input  logic [31:0] word_i,
  output logic [31:0] crc_o
);

  logic [31:0] mix;

  always_comb begin
    mix   = crc_i ^ word_i;
    crc_o = '0;
    for (int i = 0; i < 32; i++) begin
      if (mix[i]) begin
        crc_o = crc_o ^ frp_pkg::CRC_COLS[i];
      end
    end
  end

endmodule

// ----- hw/rtl/frp_core.sv -----
// ----------------------------------------------------------------------------
// Frame parser core
// Holds the per-frame state and works out the result for one byte beat.
// ----------------------------------------------------------------------------
module frp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [16:0]         length_limit_i,
  output frp_pkg::frp_result_t result_o
);

  logic [16:0] pos_q, pos_d;
  logic [23:0] hdr_q, hdr_d;
  logic [23:0] lenb_q, lenb_d;
  logic [15:0] crc_end_q, crc_end_d;
  logic [15:0] last_q, last_d;
  logic [15:0] flen_q, flen_d;
  logic [31:0] crc_q, crc_d;
  logic [23:0] wcol_q, wcol_d;
  logic [55:0] trl_q, trl_d;

  logic [1:0]  lane;
  logic [16:0] lim;
  logic [31:0] len32;
  logic        len_ok;
  logic        crc_en;
  logic        pad;
  logic        do_word;
  logic        clear;
  logic [31:0] word;
  logic [31:0] crc_upd;
  logic [31:0] rx_crc;
  frp_pkg::frp_status_e status;

  assign lane    = pos_q[1:0];
  assign lim     = (length_limit_i > frp_pkg::LIMIT_CAP) ? frp_pkg::LIMIT_CAP : length_limit_i;
  assign len32   = {rx_byte_i, lenb_q};
  assign len_ok  = (len32 >= frp_pkg::MIN_LEN) && (len32 < {15'd0, lim});
  assign rx_crc  = {trl_q[31:24], trl_q[39:32], trl_q[47:40], trl_q[55:48]};
  assign do_word = pad || (crc_en && (lane == 2'd3));
  assign word    = pad ? {8'h00, wcol_q} : {rx_byte_i, wcol_q};

  frp_crc32_word u_crc (
    .crc_i  (crc_q),
    .word_i (word),
    .crc_o  (crc_upd)
  );

  always_comb begin
    pos_d     = pos_q + 17'd1;
    hdr_d     = hdr_q;
    lenb_d    = lenb_q;
    crc_end_d = crc_end_q;
    last_d    = last_q;
    flen_d    = flen_q;
    crc_d     = crc_q;
    wcol_d    = wcol_q;
    trl_d     = {trl_q[47:0], rx_byte_i};
    status    = frp_pkg::FRP_PROGRESS;
    clear     = 1'b0;
    crc_en    = 1'b0;
    pad       = 1'b0;

    if (pos_q < frp_pkg::HDR_LEN) begin
      crc_en = 1'b1;
      hdr_d  = {hdr_q[15:0], rx_byte_i};
      if ((lane == 2'd3) && ({hdr_q, rx_byte_i} != frp_pkg::HDR_WORD)) begin
        status = frp_pkg::FRP_HDR_BAD;
        clear  = 1'b1;
      end
    end else if (pos_q < frp_pkg::PREFIX_LEN) begin
      crc_en = 1'b1;
      lenb_d = {rx_byte_i, lenb_q[23:8]};
      if (lane == 2'd3) begin
        if (len_ok) begin
          crc_end_d = len32[15:0] - frp_pkg::PREFIX_LEN[15:0];
          last_d    = len32[15:0] - 16'd1;
          flen_d    = len32[15:0];
        end else begin
          status = frp_pkg::FRP_LEN_BAD;
          clear  = 1'b1;
        end
      end
    end else begin
      if (pos_q < {1'b0, crc_end_q}) begin
        crc_en = 1'b1;
      end else if ((pos_q == {1'b0, crc_end_q}) && (crc_end_q[1:0] != 2'd0)) begin
        pad = 1'b1;
      end
      if (pos_q == {1'b0, last_q}) begin
        if (({trl_q[23:0], rx_byte_i} == frp_pkg::TAIL_WORD) && (rx_crc == crc_q)) begin
          status = frp_pkg::FRP_GOOD;
        end else begin
          status = frp_pkg::FRP_TAIL_BAD;
        end
        clear = 1'b1;
      end
    end

    if (do_word) begin
      crc_d  = crc_upd;
      wcol_d = '0;
    end else if (crc_en) begin
      wcol_d = wcol_q | ({16'h0000, rx_byte_i} << {lane, 3'b000});
    end

    if (clear) begin
      pos_d     = '0;
      hdr_d     = '0;
      lenb_d    = '0;
      crc_end_d = '0;
      last_d    = '0;
      flen_d    = '0;
      crc_d     = frp_pkg::CRC_INIT;
      wcol_d    = '0;
    end
  end

  always_comb begin
    result_o.data_byte    = rx_byte_i;
    result_o.byte_offset  = pos_q[15:0];
    result_o.in_frame     = (status == frp_pkg::FRP_PROGRESS);
    result_o.status       = status;
    result_o.frame_length = (status == frp_pkg::FRP_GOOD) ? flen_q : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_q     <= '0;
      lenb_q    <= '0;
      crc_end_q <= '0;
      last_q    <= '0;
      flen_q    <= '0;
      crc_q     <= frp_pkg::CRC_INIT;
      wcol_q    <= '0;
      trl_q     <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      hdr_q     <= hdr_d;
      lenb_q    <= lenb_d;
      crc_end_q <= crc_end_d;
      last_q    <= last_d;
      flen_q    <= flen_d;
      crc_q     <= crc_d;
      wcol_q    <= wcol_d;
      trl_q     <= trl_d;
    end
  end

endmodule

// ----- hw/rtl/framed_packet_receiver_crc32.sv -----
// ----------------------------------------------------------------------------
// Framed packet receiver with CRC-32 check
// Parses length-prefixed frames byte by byte and echoes each byte with its
// offset and the frame verdict.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   rx_byte_i
//   out      source     out_valid_o / out_stall_i data_byte_o, byte_offset_o,
//                                                 in_frame_o, status_o,
//                                                 frame_length_o
//   cfg      APB slave  psel/penable/pready       length_limit at 0x0
//
// One beat per clock sustained while the output is not stalled; a byte's result
// reaches the output through the input register, then the result register.
// The CRC update is one XOR matrix pass per 4 bytes and per padded last word.
// Reset clears the frame state and sets length_limit to 4096.
// A stalled output holds its beat; the input stalls only while both registers
// are full and the output is stalled.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_offset_o,
  output logic        in_frame_o,
  output logic [2:0]  status_o,
  output logic [15:0] frame_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0]          limit_q;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  frp_pkg::frp_result_t out_res_q;
  frp_pkg::frp_result_t res;
  logic                 adv;
  logic                 step;
  logic                 accept;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == frp_pkg::REG_LENGTH_LIMIT);
  assign prdata = (paddr[2] == frp_pkg::REG_LENGTH_LIMIT) ? {15'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= frp_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[16:0];
    end
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = adv && in_valid_q;
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  frp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .rx_byte_i      (in_byte_q),
    .length_limit_i (limit_q),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_res_q.data_byte;
  assign byte_offset_o  = out_res_q.byte_offset;
  assign in_frame_o     = out_res_q.in_frame;
  assign status_o       = out_res_q.status;
  assign frame_length_o = out_res_q.frame_length;

endmodule
